@@ sv/instruction_word_screen_core_assert.svh @@
// Assertion macros for the instruction word screen core.
`ifndef INSTRUCTION_WORD_SCREEN_CORE_ASSERT_SVH
`define INSTRUCTION_WORD_SCREEN_CORE_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define IWS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("iws assertion failed");

// Check a consequent in the cycle after its antecedent.
`define IWS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("iws assertion failed");

`endif

@@ sv/iws_pkg.sv @@
// Shared widths, opcodes and constants of the instruction word screen.
package iws_pkg;

  localparam int unsigned WORD_W         = 32;
  localparam int unsigned ENTRY_W        = 64;
  localparam int unsigned SYSTEM_ENTRIES = 1024;
  localparam int unsigned BASE_ENTRIES   = 256;
  localparam int unsigned SYS_IDX_W      = $clog2(SYSTEM_ENTRIES);
  localparam int unsigned BASE_IDX_W     = $clog2(BASE_ENTRIES);
  localparam int unsigned HASH_W         = 11;
  localparam int unsigned OP_W           = 2;
  localparam int unsigned SYS_CMP_SHIFT  = 5;

  localparam logic [9:0] SYS_CLASS_TAG = 10'd852;

  localparam logic [OP_W-1:0] OP_SCREEN     = 2'd0;
  localparam logic [OP_W-1:0] OP_SYS_WRITE  = 2'd1;
  localparam logic [OP_W-1:0] OP_BASE_WRITE = 2'd2;

endpackage

@@ sv/iws_in_if.sv @@
// Input channel: screen and table write words.
interface iws_in_if;
  logic                             valid;
  logic                             ready;
  logic [iws_pkg::OP_W-1:0]         opcode;
  logic [iws_pkg::WORD_W-1:0]       word;
  logic [iws_pkg::SYS_IDX_W-1:0]    entry_index;
  logic [iws_pkg::ENTRY_W-1:0]      entry_data;

  modport source (output valid, opcode, word, entry_index, entry_data, input ready);
  modport sink   (input valid, opcode, word, entry_index, entry_data, output ready);
endinterface

@@ sv/iws_out_if.sv @@
// Output channel: screen result words.
interface iws_out_if;
  logic                             valid;
  logic                             ready;
  logic                             is_system;
  logic                             flagged;
  logic signed [iws_pkg::HASH_W-1:0] hash_index;

  modport source (output valid, is_system, flagged, hash_index, input ready);
  modport sink   (input valid, is_system, flagged, hash_index, output ready);
endinterface

@@ sv/instruction_word_screen_core.sv @@
// Instruction word screen core: classify, hash and check words against two tables.
//
// Takes one word per cycle except while ready is low, in the clearing pass or a stall;
// a screen word's result is registered in stage 1, then in the output stage; table
// writes return nothing and a screen word right after a write sees the new entry. Each
// table is a single-port-write, single-port-read memory with registered read data.
// After reset a clearing pass zeroes both tables, one entry a cycle, ready held low.
`include "instruction_word_screen_core_assert.svh"

module instruction_word_screen_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  iws_in_if.sink    in_i,
  iws_out_if.source out_o
);
  import iws_pkg::*;

  logic [WORD_W-1:0]  sys_mem  [SYSTEM_ENTRIES];
  logic [ENTRY_W-1:0] base_mem [BASE_ENTRIES];

  logic [SYS_IDX_W-1:0] clr_cnt_q;
  logic                 clr_done_q;

  logic                 in_fire;
  logic                 s1_advance;
  logic                 is_sys;
  logic signed [HASH_W-1:0] sys_slot;
  logic [BASE_IDX_W-1:0] base_idx;

  logic                 sys_we;
  logic [SYS_IDX_W-1:0] sys_wr_addr;
  logic [WORD_W-1:0]    sys_wr_data;
  logic                 base_we;
  logic [BASE_IDX_W-1:0] base_wr_addr;
  logic [ENTRY_W-1:0]   base_wr_data;

  logic                 s1_valid_q;
  logic [WORD_W-1:0]    s1_word_q;
  logic                 s1_is_sys_q;
  logic signed [HASH_W-1:0] s1_hash_q;
  logic                 s1_in_range_q;
  logic [WORD_W-1:0]    sys_rd_q;
  logic [ENTRY_W-1:0]   base_rd_q;

  logic [WORD_W-1:0]    sys_entry;
  logic [WORD_W-1:0]    base_mask;
  logic [WORD_W-1:0]    base_pat;
  logic                 flag_d;

  logic                 out_valid_q;
  logic                 out_is_sys_q;
  logic                 out_flag_q;
  logic signed [HASH_W-1:0] out_hash_q;

  assign s1_advance = !out_valid_q || out_o.ready;
  assign in_i.ready = clr_done_q && (!s1_valid_q || s1_advance);
  assign in_fire    = in_i.valid && in_i.ready;

  assign is_sys = (in_i.word[31:22] == SYS_CLASS_TAG) &&
                  ((in_i.word[20:19] == 2'b01) || in_i.word[20]);
  assign sys_slot = $signed({1'b0, in_i.word[21:12]}) - $signed({4'b0000, in_i.word[11:5]});
  assign base_idx = {in_i.word[25:24], in_i.word[13], in_i.word[7:5], in_i.word[1:0]};

  always_comb begin
    sys_we       = 1'b0;
    sys_wr_addr  = clr_cnt_q;
    sys_wr_data  = '0;
    base_we      = 1'b0;
    base_wr_addr = clr_cnt_q[BASE_IDX_W-1:0];
    base_wr_data = '0;
    if (!clr_done_q) begin
      sys_we  = 1'b1;
      base_we = 1'b1;
    end else if (in_fire) begin
      case (in_i.opcode)
        OP_SYS_WRITE: begin
          sys_we      = 1'b1;
          sys_wr_addr = in_i.entry_index;
          sys_wr_data = in_i.entry_data[WORD_W-1:0];
        end
        OP_BASE_WRITE: begin
          base_we      = 1'b1;
          base_wr_addr = in_i.entry_index[BASE_IDX_W-1:0];
          base_wr_data = in_i.entry_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_done_q <= 1'b0;
    end else if (!clr_done_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == SYS_IDX_W'(SYSTEM_ENTRIES - 1)) begin
        clr_done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sys_we) begin
      sys_mem[sys_wr_addr] <= sys_wr_data;
    end
    if (in_fire) begin
      sys_rd_q <= sys_mem[sys_slot[SYS_IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (base_we) begin
      base_mem[base_wr_addr] <= base_wr_data;
    end
    if (in_fire) begin
      base_rd_q <= base_mem[base_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= (in_i.opcode == OP_SCREEN);
    end else if (s1_advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_word_q     <= in_i.word;
      s1_is_sys_q   <= is_sys;
      s1_hash_q     <= is_sys ? sys_slot : $signed({3'b000, base_idx});
      s1_in_range_q <= !sys_slot[HASH_W-1];
    end
  end

  assign sys_entry = s1_in_range_q ? sys_rd_q : '0;
  assign base_mask = base_rd_q[ENTRY_W-1:WORD_W];
  assign base_pat  = base_rd_q[WORD_W-1:0];

  always_comb begin
    if (s1_is_sys_q) begin
      flag_d = !((sys_entry != '0) &&
                 (s1_word_q[WORD_W-1:SYS_CMP_SHIFT] == sys_entry[WORD_W-1:SYS_CMP_SHIFT]));
    end else begin
      flag_d = (base_rd_q != '0) && ((s1_word_q & base_mask) == base_pat);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance && s1_valid_q) begin
      out_is_sys_q <= s1_is_sys_q;
      out_flag_q   <= flag_d;
      out_hash_q   <= s1_hash_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.is_system  = out_is_sys_q;
  assign out_o.flagged    = out_flag_q;
  assign out_o.hash_index = out_hash_q;

  `IWS_ASSERT_SAME(a_ready_after_clear, in_i.ready, clr_done_q)
  `IWS_ASSERT_NEXT(a_screen_enters_s1, in_fire && (in_i.opcode == OP_SCREEN), s1_valid_q)
  `IWS_ASSERT_NEXT(a_write_no_result, in_fire && (in_i.opcode != OP_SCREEN), !s1_valid_q)
  `IWS_ASSERT_SAME(a_sys_pass_in_range,
                   out_valid_q && out_is_sys_q && !out_flag_q, !out_hash_q[HASH_W-1])
  `IWS_ASSERT_SAME(a_base_hash_narrow,
                   out_valid_q && !out_is_sys_q, out_hash_q[HASH_W-1:BASE_IDX_W] == '0)

endmodule

@@ verif/tb_instruction_word_screen_core.sv @@
// Testbench for instruction_word_screen_core: directed and random screen and table-write words checked by a predictor.
module tb_instruction_word_screen_core;
  timeunit 1ns;
  timeprecision 1ps;

  import iws_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int TARGET_WORDS = 600;
  localparam int MAX_IDLE     = 8;
  localparam int DRAIN_CYCLES = 16;
  localparam int PLAN_ROWS    = 22;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [WORD_W-1:0]    word;
    logic [SYS_IDX_W-1:0] idx;
    logic [ENTRY_W-1:0]   data;
  } word_t;

  typedef struct packed {
    logic        is_sys;
    logic        flag;
    logic [10:0] hash;
  } verdict_t;

  typedef struct packed {
    word_t    item;
    bit       typed;
    verdict_t res;
  } row_t;

  logic clk_i;
  logic rst_ni;

  iws_in_if  in_ch ();
  iws_out_if out_ch ();

  instruction_word_screen_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  logic [31:0] sys_image  [SYSTEM_ENTRIES];
  logic [63:0] base_image [BASE_ENTRIES];
  verdict_t    pending_verdicts [$];

  int  mismatches;
  int  words_sent;
  int  n_screens;
  int  n_system;
  int  n_flagged;
  int  n_sys_writes;
  int  n_base_writes;
  int  n_ignored;
  bit  calm_in;
  bit  calm_out;

  row_t plan [PLAN_ROWS] = '{
    '{'{OP_SCREEN, 32'h0000_0000, 10'd0, 64'd0}, 1'b1, '{1'b0, 1'b0, 11'd0}},
    '{'{OP_SCREEN, 32'hFFFF_FFFF, 10'd0, 64'd0}, 1'b1, '{1'b0, 1'b0, 11'd255}},
    '{'{OP_SCREEN, 32'hD510_0000, 10'd0, 64'd0}, 1'b1, '{1'b1, 1'b1, 11'd256}},
    '{'{OP_SCREEN, 32'hD53F_F000, 10'd0, 64'd0}, 1'b1, '{1'b1, 1'b1, 11'd1023}},
    '{'{OP_SCREEN, 32'hD508_0FE0, 10'd0, 64'd0}, 1'b1, '{1'b1, 1'b1, 11'd1}},
    '{'{OP_SCREEN, 32'hD500_0000, 10'd0, 64'd0}, 1'b1, '{1'b0, 1'b0, 11'd64}},
    '{'{OP_SCREEN, 32'hD518_0000, 10'd0, 64'd0}, 1'b1, '{1'b1, 1'b1, 11'd384}},
    '{'{OP_UNUSED, 32'hFFFF_FFFF, 10'h3FF, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, '0},
    '{'{OP_SYS_WRITE, 32'h0, 10'd256, 64'hFFFF_FFFF_D510_001F}, 1'b0, '0},
    '{'{OP_SCREEN, 32'hD510_0000, 10'd0, 64'd0}, 1'b0, '0},
    '{'{OP_SCREEN, 32'hD510_0003, 10'h3FF, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, '0},
    '{'{OP_SYS_WRITE, 32'h0, 10'd1023, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, '0},
    '{'{OP_SCREEN, 32'hD53F_F000, 10'd0, 64'd0}, 1'b0, '0},
    '{'{OP_SYS_WRITE, 32'hFFFF_FFFF, 10'd0, 64'd0}, 1'b0, '0},
    '{'{OP_BASE_WRITE, 32'h0, 10'h3FF, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, '0},
    '{'{OP_SCREEN, 32'hFFFF_FFFF, 10'd0, 64'd0}, 1'b0, '0},
    '{'{OP_BASE_WRITE, 32'h0, 10'd0, 64'h0000_0001_0000_0000}, 1'b0, '0},
    '{'{OP_SCREEN, 32'h0000_0000, 10'd0, 64'd0}, 1'b0, '0},
    '{'{OP_BASE_WRITE, 32'h0, 10'd64, 64'd0}, 1'b0, '0},
    '{'{OP_SCREEN, 32'hD500_0000, 10'd0, 64'd0}, 1'b0, '0},
    '{'{OP_BASE_WRITE, 32'h0, 10'h100, 64'h0000_0000_0000_0001}, 1'b0, '0},
    '{'{OP_SCREEN, 32'h0000_0000, 10'd0, 64'd0}, 1'b0, '0}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("instruction_word_screen_core verification failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic int draw_idle(inout bit calm);
    if ($urandom_range(0, 29) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  function automatic logic [7:0] base_slot(input logic [31:0] w);
    return {w[25:24], w[13], w[7:5], w[1:0]};
  endfunction

  function automatic int sys_slot(input logic [31:0] w);
    return int'(w[21:12]) - int'(w[11:5]);
  endfunction

  function automatic bit is_sys_word(input logic [31:0] w);
    return (w[31:22] == SYS_CLASS_TAG) && ((w[20:19] == 2'b01) || w[20]);
  endfunction

  function automatic logic [31:0] rand_sys_word();
    logic [31:0] w;
    w = $urandom;
    w[31:22] = SYS_CLASS_TAG;
    w[20:19] = 2'($urandom_range(1, 3));
    return w;
  endfunction

  function automatic word_t make_word(input logic [OP_W-1:0] op, input logic [31:0] w,
                                      input logic [9:0] idx, input logic [63:0] data);
    word_t it;
    it.op   = op;
    it.word = w;
    it.idx  = idx;
    it.data = data;
    return it;
  endfunction

  // Apply one accepted word to the table images; return 1 when it yields a result.
  function automatic bit screen_predict(input word_t it, output verdict_t v);
    int          h;
    logic [31:0] se;
    logic [63:0] be;
    logic [7:0]  b;
    v = '0;
    case (it.op)
      OP_SYS_WRITE: begin
        sys_image[it.idx] = it.data[31:0];
        n_sys_writes++;
        return 1'b0;
      end
      OP_BASE_WRITE: begin
        base_image[it.idx[7:0]] = it.data;
        n_base_writes++;
        return 1'b0;
      end
      OP_SCREEN: ;
      default: begin
        n_ignored++;
        return 1'b0;
      end
    endcase
    n_screens++;
    if (is_sys_word(it.word)) begin
      h = sys_slot(it.word);
      se = (h >= 0 && h < int'(SYSTEM_ENTRIES)) ? sys_image[h] : 32'd0;
      v.is_sys = 1'b1;
      v.flag   = !((se != 32'd0) && (se[31:5] == it.word[31:5]));
      v.hash   = h[10:0];
    end else begin
      b = base_slot(it.word);
      be = base_image[b];
      v.is_sys = 1'b0;
      v.flag   = (be != 64'd0) && ((it.word & be[63:32]) == be[31:0]);
      v.hash   = {3'b000, b};
    end
    n_system  += v.is_sys;
    n_flagged += v.flag;
    return 1'b1;
  endfunction

  task automatic send_word(input word_t it, input bit typed, input verdict_t typed_v);
    int       gap;
    verdict_t v;
    gap = draw_idle(calm_in);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= it.op;
    in_ch.word        <= it.word;
    in_ch.entry_index <= it.idx;
    in_ch.entry_data  <= it.data;
    do @(posedge clk_i); while (!in_ch.ready);
    if (it.op != OP_UNUSED) words_sent++;
    if (screen_predict(it, v)) pending_verdicts.push_back(typed ? typed_v : v);
  endtask

  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = draw_idle(calm_out);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result word with nothing pending");
      end else begin
        want = pending_verdicts.pop_front();
        if (out_ch.is_system !== want.is_sys)
          report_mismatch($sformatf("is_system got %b want %b", out_ch.is_system, want.is_sys));
        if (out_ch.flagged !== want.flag)
          report_mismatch($sformatf("flagged got %b want %b", out_ch.flagged, want.flag));
        if (out_ch.hash_index !== want.hash)
          report_mismatch($sformatf("hash_index got %0d want %0d",
                                    $signed(out_ch.hash_index), $signed(want.hash)));
      end
    end
  end

  initial begin
    word_t       it;
    verdict_t    none;
    logic [31:0] w;
    logic [31:0] w2;
    logic [31:0] m;
    logic [31:0] p;
    int          h;
    none = '0;
    rst_ni            = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = OP_SCREEN;
    in_ch.word        = '0;
    in_ch.entry_index = '0;
    in_ch.entry_data  = '0;
    foreach (sys_image[i]) sys_image[i] = '0;
    foreach (base_image[i]) base_image[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) send_word(plan[i].item, plan[i].typed, plan[i].res);

    while (words_sent < TARGET_WORDS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          w = rand_sys_word();
          h = sys_slot(w);
          send_word(make_word(OP_SYS_WRITE, $urandom, 10'(h),
                              {32'($urandom), w[31:5], 5'($urandom)}), 1'b0, none);
          w2 = w;
          case ($urandom_range(0, 3))
            0: w2[4:0] = 5'($urandom);
            1: w2[5 + $urandom_range(0, 26)] ^= 1'b1;
            default: ;
          endcase
          send_word(make_word(OP_SCREEN, w2, 10'($urandom), {$urandom, $urandom}), 1'b0, none);
        end
        3, 4: begin
          w = $urandom;
          m = $urandom;
          p = w & m;
          if ($urandom_range(0, 3) == 0) p[$urandom_range(0, 31)] ^= 1'b1;
          send_word(make_word(OP_BASE_WRITE, $urandom, {2'($urandom), base_slot(w)}, {m, p}),
                    1'b0, none);
          send_word(make_word(OP_SCREEN, w, 10'($urandom), {$urandom, $urandom}), 1'b0, none);
        end
        5, 6: begin
          w = $urandom_range(0, 1) ? rand_sys_word() : 32'($urandom);
          send_word(make_word(OP_SCREEN, w, 10'($urandom), {$urandom, $urandom}), 1'b0, none);
        end
        7: send_word(make_word(OP_SYS_WRITE, $urandom, 10'($urandom), {$urandom, $urandom}),
                     1'b0, none);
        8: send_word(make_word(OP_BASE_WRITE, $urandom, 10'($urandom), {$urandom, $urandom}),
                     1'b0, none);
        default: send_word(make_word(OP_UNUSED, $urandom, 10'($urandom), {$urandom, $urandom}),
                           1'b0, none);
      endcase
    end
    in_ch.valid <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Screened %0d words (%0d system class, %0d flagged) between %0d system",
             n_screens, n_system, n_flagged, n_sys_writes);
    $display("and %0d base table writes, plus %0d unused-opcode words; %0d mismatches.",
             n_base_writes, n_ignored, mismatches);
    if (mismatches == 0) begin
      $display("instruction_word_screen_core verification clean");
    end else begin
      $display("instruction_word_screen_core verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/iws_pkg.sv
sv/iws_in_if.sv
sv/iws_out_if.sv
sv/instruction_word_screen_core.sv
verif/tb_instruction_word_screen_core.sv
